[design/lrrp_pkg.sv]
package lrrp_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ADDR_W      = 8;
    localparam int IFACE_W     = 8;
    localparam int KEY_W       = ADDR_W + IFACE_W;
    localparam int TIME_W      = 64;
    localparam int INTERVAL_W  = 32;
    localparam int ATTEMPT_W   = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [INTERVAL_W-1:0] RESET_MIN_INTERVAL_US  = INTERVAL_W'(250000);
    localparam logic [ATTEMPT_W-1:0]  RESET_BOOT_ATTEMPT_LIM = ATTEMPT_W'(20);

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL_US    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_ATTEMPT_LIMIT = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        MODE_CONNECT    = 2'd0,
        MODE_DISCONNECT = 2'd1,
        MODE_REPORT     = 2'd2,
        MODE_BOOT_POLL  = 2'd3
    } lrrp_mode_t;

    typedef struct packed {
        lrrp_mode_t           mode;
        logic [ADDR_W-1:0]    device;
        logic [IFACE_W-1:0]   iface;
        logic [TIME_W-1:0]    now_us;
    } lrrp_cmd_t;

    typedef struct packed {
        logic send_request;
        logic key_known;
        logic insert_dropped;
    } lrrp_result_t;

    typedef struct packed {
        logic hit;
        logic full;
        logic empty;
        logic removed;
    } lrrp_tbl_status_t;

    typedef struct packed {
        logic report;
        logic boot;
    } lrrp_req_t;

endpackage

[design/lrrp_key_table.sv]
module lrrp_key_table
    import lrrp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             act,
    input  lrrp_cmd_t        cmd,
    output lrrp_tbl_status_t status
);

    logic [KEY_W-1:0]       key_table_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] key_valid_reg;
    logic [TABLE_DEPTH-1:0] key_valid_next;
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [TABLE_DEPTH-1:0] addr_vec;
    logic [KEY_W-1:0]       key;
    logic [SLOT_W-1:0]      free_slot;
    logic                   free_found;
    logic                   insert;

    always_comb
    begin
        key        = {cmd.device, cmd.iface};
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_vec[i]  = key_valid_reg[i] && (key_table_reg[i] == key);
            addr_vec[i] = key_valid_reg[i] &&
                          (key_table_reg[i][KEY_W-1:IFACE_W] == cmd.device);
        end
        // scan downwards so the lowest free slot wins
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!key_valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    assign insert = act && (cmd.mode == MODE_CONNECT) && !(|hit_vec) && free_found;

    always_comb
    begin
        key_valid_next = key_valid_reg;
        if (insert)
        begin
            key_valid_next[free_slot] = 1'b1;
        end
        if (act && (cmd.mode == MODE_DISCONNECT))
        begin
            key_valid_next = key_valid_reg & ~addr_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= '0;
        end
        else
        begin
            key_valid_reg <= key_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            key_table_reg[free_slot] <= key;
        end
    end

    assign status.hit     = |hit_vec;
    assign status.full    = &key_valid_reg;
    assign status.empty   = ~(|key_valid_reg);
    assign status.removed = |addr_vec;

endmodule

[design/lrrp_throttle.sv]
module lrrp_throttle
    import lrrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrrp_req_t             req,
    input  logic [TIME_W-1:0]     now_us,
    input  logic [INTERVAL_W-1:0] min_interval_us,
    input  logic [ATTEMPT_W-1:0]  boot_attempt_limit,
    output logic                  send
);

    logic [TIME_W-1:0]    next_allowed_reg;
    logic [ATTEMPT_W-1:0] boot_attempts_reg;
    logic                 allowed;
    logic                 boot_ok;

    assign allowed = (now_us >= next_allowed_reg);
    assign boot_ok = (boot_attempts_reg < boot_attempt_limit);
    assign send    = allowed && (req.report || (req.boot && boot_ok));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_allowed_reg  <= '0;
            boot_attempts_reg <= '0;
        end
        else
        begin
            if (send)
            begin
                next_allowed_reg <= now_us + TIME_W'(min_interval_us);
            end
            if (send && req.boot)
            begin
                boot_attempts_reg <= boot_attempts_reg + ATTEMPT_W'(1);
            end
        end
    end

endmodule

[design/link_resync_request_policy.sv]
// Resync request policy for a link that carries device connect, disconnect
// and report events.
// Command channel: a word on cmd is taken at a rising edge with start high
// and busy low. busy is never raised, so a word may be given every cycle.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 sets min_interval_us, index 1 sets boot_attempt_limit, others are
// ignored. cfg_ready is always high. Write only while no command is in flight.
// Result channel: each command gives exactly one word on result, shown for
// one cycle with done high from the edge after the command is taken; the
// command passes the input register, then table match and throttle check
// into the result register.
// Throughput is one command per cycle; the table and throttle state update
// at the edge that loads the result, so the next command already sees it.
// The receiver cannot stall; every result is taken in its done cycle.
// Reset clears the key valid bits, throttle time, boot attempt count and
// restores the configuration defaults (250000 us, 20 attempts).
module link_resync_request_policy
    import lrrp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  lrrp_cmd_t              cmd,
    output logic                   done,
    output lrrp_result_t           result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                  cmd_vld_reg;
    lrrp_cmd_t             cmd_reg;
    logic                  done_reg;
    lrrp_result_t          result_reg;
    lrrp_result_t          result_next;
    logic [INTERVAL_W-1:0] min_interval_reg;
    logic [ATTEMPT_W-1:0]  boot_limit_reg;
    lrrp_tbl_status_t      tbl_status;
    lrrp_req_t             req;
    logic                  send;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= RESET_MIN_INTERVAL_US;
            boot_limit_reg   <= RESET_BOOT_ATTEMPT_LIM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MIN_INTERVAL_US)
            begin
                min_interval_reg <= cfg_data[INTERVAL_W-1:0];
            end
            else if (cfg_index == CFG_BOOT_ATTEMPT_LIMIT)
            begin
                boot_limit_reg <= cfg_data[ATTEMPT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            cmd_vld_reg <= start && !busy;
            done_reg    <= cmd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        if (cmd_vld_reg)
        begin
            result_reg <= result_next;
        end
    end

    lrrp_key_table u_key_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .act    (cmd_vld_reg),
        .cmd    (cmd_reg),
        .status (tbl_status)
    );

    assign req.report = cmd_vld_reg && (cmd_reg.mode == MODE_REPORT) && !tbl_status.hit;
    assign req.boot   = cmd_vld_reg && (cmd_reg.mode == MODE_BOOT_POLL) && tbl_status.empty;

    lrrp_throttle u_throttle (
        .clk                (clk),
        .rst_n              (rst_n),
        .req                (req),
        .now_us             (cmd_reg.now_us),
        .min_interval_us    (min_interval_reg),
        .boot_attempt_limit (boot_limit_reg),
        .send               (send)
    );

    always_comb
    begin
        result_next.send_request   = send;
        result_next.key_known      = 1'b0;
        result_next.insert_dropped = 1'b0;
        case (cmd_reg.mode)
            MODE_CONNECT:
            begin
                result_next.key_known      = tbl_status.hit;
                result_next.insert_dropped = !tbl_status.hit && tbl_status.full;
            end
            MODE_DISCONNECT:
            begin
                result_next.key_known = tbl_status.removed;
            end
            MODE_REPORT:
            begin
                result_next.key_known = tbl_status.hit;
            end
            default:
            begin
                result_next.key_known = 1'b0;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[bench/tb_link_resync_request_policy.sv]
module tb_link_resync_request_policy;
    import lrrp_pkg::*;

    localparam lrrp_result_t QUIET  = 3'b000;
    localparam lrrp_result_t REPLAY = 3'b100;
    localparam lrrp_result_t KNOWN  = 3'b010;
    localparam lrrp_result_t DROP   = 3'b001;

    typedef struct {
        lrrp_cmd_t    word;
        logic         fixed;
        lrrp_result_t want;
    } probe_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    lrrp_cmd_t              cmd = '0;
    logic                   done;
    lrrp_result_t           result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   row_fixed = 1'b0;
    lrrp_result_t           row_want = QUIET;

    logic [KEY_W-1:0]       seen_keys [TABLE_DEPTH];
    logic                   seen_live [TABLE_DEPTH];
    logic [TIME_W-1:0]      replay_after;
    logic [ATTEMPT_W-1:0]   boot_sent;
    logic [INTERVAL_W-1:0]  gap_us;
    logic [ATTEMPT_W-1:0]   boot_cap;

    lrrp_result_t           pending_results [$];
    int                     errors = 0;
    logic [TIME_W-1:0]      wall_us = '0;

    link_resync_request_policy uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic replay_allowed(input logic [TIME_W-1:0] t);
        if (t < replay_after)
            return 1'b0;
        replay_after = t + TIME_W'(gap_us);
        return 1'b1;
    endfunction

    function automatic lrrp_result_t resolve_event(input lrrp_cmd_t c);
        lrrp_result_t     r;
        logic [KEY_W-1:0] key;
        logic             hit;
        logic             empty;
        int               slot;
        r = QUIET;
        key = {c.device, c.iface};
        hit = 1'b0;
        empty = 1'b1;
        slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (seen_live[i])
            begin
                empty = 1'b0;
                if (seen_keys[i] == key)
                    hit = 1'b1;
            end
            else if (slot < 0)
                slot = i;
        end
        case (c.mode)
            MODE_CONNECT:
            begin
                if (hit)
                    r.key_known = 1'b1;
                else if (slot < 0)
                    r.insert_dropped = 1'b1;
                else
                begin
                    seen_keys[slot] = key;
                    seen_live[slot] = 1'b1;
                end
            end
            MODE_DISCONNECT:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (seen_live[i] && seen_keys[i][KEY_W-1:IFACE_W] == c.device)
                    begin
                        seen_live[i] = 1'b0;
                        r.key_known = 1'b1;
                    end
                end
            end
            MODE_REPORT:
            begin
                if (hit)
                    r.key_known = 1'b1;
                else
                    r.send_request = replay_allowed(c.now_us);
            end
            default:
            begin
                if (empty && boot_sent < boot_cap && replay_allowed(c.now_us))
                begin
                    r.send_request = 1'b1;
                    boot_sent = boot_sent + 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lrrp_result_t want;
        lrrp_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                seen_keys[i] = '0;
                seen_live[i] = 1'b0;
            end
            replay_after = '0;
            boot_sent = '0;
            gap_us = RESET_MIN_INTERVAL_US;
            boot_cap = RESET_BOOT_ATTEMPT_LIM;
            pending_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.send_request !== want.send_request)
                    begin
                        $error("send_request: expected %0b, got %0b",
                               want.send_request, result.send_request);
                        errors++;
                    end
                    if (result.key_known !== want.key_known)
                    begin
                        $error("key_known: expected %0b, got %0b",
                               want.key_known, result.key_known);
                        errors++;
                    end
                    if (result.insert_dropped !== want.insert_dropped)
                    begin
                        $error("insert_dropped: expected %0b, got %0b",
                               want.insert_dropped, result.insert_dropped);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_INTERVAL_US:    gap_us = cfg_data[INTERVAL_W-1:0];
                    CFG_BOOT_ATTEMPT_LIMIT: boot_cap = cfg_data[ATTEMPT_W-1:0];
                    default:                ;
                endcase
            end
            if (start && !busy)
            begin
                got = resolve_event(cmd);
                pending_results.push_back(row_fixed ? row_want : got);
            end
        end
    end

    function automatic probe_t probe(input lrrp_mode_t m, input logic [ADDR_W-1:0] d,
                                     input logic [IFACE_W-1:0] f, input logic [TIME_W-1:0] t,
                                     input logic fixed, input lrrp_result_t w);
        probe_t p;
        p.word.mode = m;
        p.word.device = d;
        p.word.iface = f;
        p.word.now_us = t;
        p.fixed = fixed;
        p.want = w;
        return p;
    endfunction

    function automatic lrrp_cmd_t random_word();
        lrrp_cmd_t                     c;
        logic [ADDR_W-1:0]             pool [6];
        logic [TIME_W-1:0]             span;
        int                            r;
        pool = '{8'h00, 8'h01, 8'h02, 8'h7F, 8'h80, 8'hFF};
        r = $urandom_range(99);
        if (r < 30)
            c.mode = MODE_CONNECT;
        else if (r < 50)
            c.mode = MODE_DISCONNECT;
        else if (r < 75)
            c.mode = MODE_REPORT;
        else
            c.mode = MODE_BOOT_POLL;
        c.device = ($urandom_range(99) < 80) ? pool[$urandom_range(5)] : ADDR_W'($urandom);
        c.iface = ($urandom_range(99) < 80) ? IFACE_W'($urandom_range(3)) : IFACE_W'($urandom);
        r = $urandom_range(99);
        if (r < 4)
            wall_us = {$urandom, $urandom};
        else if (r < 6)
            wall_us = '1 - TIME_W'($urandom_range(3000));
        else
        begin
            span = TIME_W'(gap_us) * 2 + 3;
            wall_us = wall_us + ({$urandom, $urandom} % span);
        end
        c.now_us = wall_us;
        return c;
    endfunction

    task automatic put_word(input lrrp_cmd_t c, input logic fixed, input lrrp_result_t w);
        start <= 1'b1;
        cmd <= c;
        row_fixed <= fixed;
        row_want <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic maybe_idle(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        row_fixed <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        probe_t                plan [$];
        logic [INTERVAL_W-1:0] gap;
        logic [ATTEMPT_W-1:0]  cap;
        int                    items;
        int                    pct;

        plan.push_back(probe(MODE_BOOT_POLL, 8'h00, 8'h00, 64'd0, 1'b1, REPLAY));
        plan.push_back(probe(MODE_BOOT_POLL, 8'hFF, 8'hFF, 64'd100, 1'b1, QUIET));
        plan.push_back(probe(MODE_REPORT, 8'h00, 8'h00, 64'd250000, 1'b1, REPLAY));
        plan.push_back(probe(MODE_CONNECT, 8'h00, 8'h00, 64'd0, 1'b0, QUIET));
        plan.push_back(probe(MODE_CONNECT, 8'h00, 8'h00, '1, 1'b1, KNOWN));
        plan.push_back(probe(MODE_BOOT_POLL, 8'h00, 8'h00, '1, 1'b1, QUIET));
        plan.push_back(probe(MODE_CONNECT, 8'hFF, 8'hFF, 64'd0, 1'b0, QUIET));
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            plan.push_back(probe(MODE_CONNECT, 8'h5A, IFACE_W'(i), 64'd0, 1'b0, QUIET));
        plan.push_back(probe(MODE_CONNECT, 8'hA5, 8'h01, 64'd0, 1'b1, DROP));
        plan.push_back(probe(MODE_REPORT, 8'hA5, 8'h01, 64'd1000, 1'b1, QUIET));
        plan.push_back(probe(MODE_DISCONNECT, 8'h5A, 8'h00, 64'd0, 1'b1, KNOWN));
        plan.push_back(probe(MODE_DISCONNECT, 8'h5A, 8'h00, 64'd0, 1'b1, QUIET));
        plan.push_back(probe(MODE_REPORT, 8'hFF, 8'hFF, 64'd0, 1'b1, KNOWN));
        plan.push_back(probe(MODE_DISCONNECT, 8'hFF, 8'h00, 64'd0, 1'b0, QUIET));
        plan.push_back(probe(MODE_DISCONNECT, 8'h00, 8'h00, 64'd0, 1'b0, QUIET));
        plan.push_back(probe(MODE_REPORT, 8'h07, 8'h07, '1, 1'b1, REPLAY));
        plan.push_back(probe(MODE_REPORT, 8'h07, 8'h08, 64'd0, 1'b1, QUIET));
        plan.push_back(probe(MODE_REPORT, 8'h07, 8'h08, 64'd249999, 1'b1, REPLAY));

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            put_word(plan[i].word, plan[i].fixed, plan[i].want);
            maybe_idle(15);
        end
        drain();

        for (int p = 0; p < 6; p++)
        begin
            items = 250;
            pct = 15;
            case (p)
                0:
                begin
                    gap = 32'd1;
                    cap = 8'd4;
                    items = 300;
                    pct = 0;
                end
                1:
                begin
                    gap = 32'd0;
                    cap = 8'd0;
                end
                2:
                begin
                    gap = 32'hFFFF_FFFF;
                    cap = 8'hFF;
                end
                3:
                begin
                    gap = $urandom_range(2000);
                    cap = 8'hFF;
                    write_reg(CFG_INDEX_W'(2), $urandom);
                    write_reg('1, $urandom);
                end
                4:
                begin
                    gap = RESET_MIN_INTERVAL_US;
                    cap = RESET_BOOT_ATTEMPT_LIM;
                end
                default:
                begin
                    gap = $urandom;
                    cap = ATTEMPT_W'($urandom);
                end
            endcase
            write_reg(CFG_MIN_INTERVAL_US, gap);
            write_reg(CFG_BOOT_ATTEMPT_LIMIT, ($urandom & 32'hFFFF_FF00) | CFG_DATA_W'(cap));
            wall_us = {$urandom, $urandom};
            repeat (items)
            begin
                put_word(random_word(), 1'b0, QUIET);
                maybe_idle(pct);
            end
            drain();
        end

        repeat (4)
            @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
design/lrrp_pkg.sv
design/lrrp_key_table.sv
design/lrrp_throttle.sv
design/link_resync_request_policy.sv
bench/tb_link_resync_request_policy.sv
